[hw/rtl/omni3_pkg.sv]
// Package for the three-wheel omni drive mixer.
// Types, field widths, opcodes and register indexes shared by all omni3_* modules.
// No dependencies.
`default_nettype none

package omni3_pkg;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_SPIN  = 2'd1,
    OP_BRAKE = 2'd2,
    OP_COAST = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [1:0] REG_HEADING    = 2'd0;
  localparam logic [1:0] REG_SPEED_GAIN = 2'd1;
  localparam logic [1:0] REG_NORM_GAIN  = 2'd2;

  localparam int unsigned PWM_PERIOD_DEFAULT = 899;
  localparam logic [15:0] SPEED_GAIN_RESET   = 16'd13107;
  localparam logic [15:0] NORM_GAIN_RESET    = 16'd16384;

  localparam int VEL_W   = 16;  // Q1.14 command fields
  localparam int GAIN_W  = 18;  // combined gain, Q14
  localparam int WHEEL_W = 33;  // raw wheel speed, Q30
  localparam int SPEED_W = 52;  // scaled wheel speed, Q44
  localparam int ONE_SH  = 44;  // binary point of the scaled speed
  localparam int UNIT_W  = ONE_SH + 1;
  localparam int CMP_W   = 10;
  localparam int PER_W   = 16;
  localparam int LO_W    = 22;  // low split of the magnitude for the compare multiply
  localparam int HI_W    = UNIT_W - LO_W;

  localparam logic signed [WHEEL_W-1:0] SIN60_Q16 = 33'sd56755;
  localparam logic signed [SPEED_W-1:0] SPEED_ONE = SPEED_W'(64'd1 << ONE_SH);
  localparam logic [CMP_W-1:0]          CMP_MAX   = {CMP_W{1'b1}};

  typedef logic signed [SPEED_W-1:0] speed_t;

  // wheel speeds in kinematic order, not yet rotated onto the motors
  typedef struct packed {
    opcode_t          op;
    logic [1:0]       head;
    speed_t [2:0]     speed;
  } speed_set_t;

  // per-motor direction and saturated magnitude
  typedef struct packed {
    opcode_t                 op;
    logic [2:0]              fwd;
    logic [2:0][UNIT_W-1:0]  mag;
  } drive_set_t;

  typedef struct packed {
    logic [2:0]             fwd;
    logic [2:0][CMP_W-1:0]  cmp;
  } motor_set_t;

endpackage

`default_nettype wire

[hw/rtl/omni3_mix.sv]
// Kinematic mix and gain scaling: two pipeline stages. Stage A forms raw
// wheel speeds and the combined gain; stage B scales them for OP_MOVE and
// else sets each to the spin rate. Depends on omni3_pkg.
`default_nettype none

module omni3_mix (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire omni3_pkg::opcode_t            op,
  input  wire logic [1:0]                    head,
  input  wire logic [15:0]                   velocity_x,
  input  wire logic [15:0]                   velocity_y,
  input  wire logic [15:0]                   spin_rate,
  input  wire logic [15:0]                   speed_gain,
  input  wire logic [15:0]                   norm_gain,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output omni3_pkg::speed_set_t              out_data
);
  import omni3_pkg::*;

  logic                              a_valid;
  logic                              a_ready;
  opcode_t                           a_op;
  logic [1:0]                        a_head;
  logic signed [2:0][WHEEL_W-1:0]    a_w;
  logic [GAIN_W-1:0]                 a_g;
  logic [VEL_W-1:0]                  a_spin;

  logic                              b_valid;
  logic                              b_ready;
  speed_set_t                        b_data;

  logic signed [WHEEL_W-1:0]         vx_e;
  logic signed [WHEEL_W-1:0]         vy_e;
  logic signed [WHEEL_W-1:0]         vx_half;
  logic signed [WHEEL_W-1:0]         vy_sin;
  logic [31:0]                       g_full;
  speed_set_t                        b_next;
  logic signed [SPEED_W-1:0]         g_e;
  logic signed [SPEED_W-1:0]         spin_e;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign vx_e    = WHEEL_W'($signed(velocity_x));
  assign vy_e    = WHEEL_W'($signed(velocity_y));
  assign vx_half = vx_e <<< 15;
  assign vy_sin  = vy_e * SIN60_Q16;
  assign g_full  = norm_gain * speed_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready) begin
      a_op     <= op;
      a_head   <= head;
      a_w[0]   <= -(vx_e <<< 16);
      a_w[1]   <= vx_half + vy_sin;
      a_w[2]   <= vx_half - vy_sin;
      a_g      <= g_full[31:14];
      a_spin   <= spin_rate;
    end
  end

  assign g_e    = $signed({{(SPEED_W-GAIN_W){1'b0}}, a_g});
  assign spin_e = SPEED_W'($signed(a_spin)) <<< 30;

  always_comb begin
    b_next.op   = a_op;
    b_next.head = a_head;
    for (int k = 0; k < 3; k++) begin
      if (a_op == OP_MOVE) begin
        b_next.speed[k] = SPEED_W'($signed(a_w[k])) * g_e;
      end else begin
        b_next.speed[k] = spin_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready) begin
      b_data <= b_next;
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

endmodule

`default_nettype wire

[hw/rtl/omni3_sat.sv]
// Motor rotation and saturation stage.
// Routes wheel speeds onto motors by heading, clamps to [-1, 1] and picks direction.
// Depends on omni3_pkg.
`default_nettype none

module omni3_sat (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire omni3_pkg::speed_set_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output omni3_pkg::drive_set_t       out_data
);
  import omni3_pkg::*;

  logic        c_valid;
  drive_set_t  c_data;
  drive_set_t  c_next;
  speed_t      rot [3];
  speed_t      s;
  speed_t      biased;

  assign in_ready = !c_valid || out_ready;

  // motor m takes wheel (m - head) mod 3; a heading of three acts as zero
  always_comb begin
    case (in_data.head)
      2'd1: begin
        rot[0] = $signed(in_data.speed[2]);
        rot[1] = $signed(in_data.speed[0]);
        rot[2] = $signed(in_data.speed[1]);
      end
      2'd2: begin
        rot[0] = $signed(in_data.speed[1]);
        rot[1] = $signed(in_data.speed[2]);
        rot[2] = $signed(in_data.speed[0]);
      end
      default: begin
        rot[0] = $signed(in_data.speed[0]);
        rot[1] = $signed(in_data.speed[1]);
        rot[2] = $signed(in_data.speed[2]);
      end
    endcase
  end

  always_comb begin
    s          = '0;
    biased     = '0;
    c_next.op  = in_data.op;
    c_next.fwd = '0;
    c_next.mag = '0;
    for (int m = 0; m < 3; m++) begin
      s = rot[m];
      if (s > SPEED_ONE) begin
        s = SPEED_ONE;
      end else if (s < -SPEED_ONE) begin
        s = -SPEED_ONE;
      end
      biased = SPEED_ONE + s;
      c_next.fwd[m] = !s[SPEED_W-1];
      c_next.mag[m] = s[SPEED_W-1] ? biased[UNIT_W-1:0] : s[UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (in_ready) begin
      c_valid <= in_valid;
    end
    if (in_ready) begin
      c_data <= c_next;
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

`default_nettype wire

[hw/rtl/omni3_pwm.sv]
// PWM compare stages: split multiply by the period, then shift, clamp and override.
// The last stage is the block's output register.
// Depends on omni3_pkg.
`default_nettype none

module omni3_pwm #(
  parameter int unsigned PWM_PERIOD = omni3_pkg::PWM_PERIOD_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire omni3_pkg::drive_set_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output omni3_pkg::motor_set_t       out_data
);
  import omni3_pkg::*;

  localparam logic [PER_W-1:0] PERIOD = PER_W'(PWM_PERIOD);
  localparam logic [CMP_W-1:0] COAST_CMP =
      (PERIOD > PER_W'(CMP_MAX)) ? CMP_MAX : PERIOD[CMP_W-1:0];
  localparam int HP_W = PER_W + HI_W;
  localparam int LP_W = PER_W + LO_W;

  logic                        d_valid;
  logic                        d_ready;
  opcode_t                     d_op;
  logic [2:0]                  d_fwd;
  logic [2:0][HP_W-1:0]        d_hi;
  logic [2:0][LP_W-1:0]        d_lo;

  logic                        e_valid;
  logic                        e_ready;
  motor_set_t                  e_data;
  motor_set_t                  e_next;

  logic [HP_W:0]               t;
  logic [HP_W:0]               q;

  assign e_ready  = !e_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign in_ready = d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= in_valid;
    end
    if (d_ready) begin
      d_op  <= in_data.op;
      d_fwd <= in_data.fwd;
      for (int m = 0; m < 3; m++) begin
        d_hi[m] <= HP_W'(PERIOD) * HP_W'(in_data.mag[m][UNIT_W-1:LO_W]);
        d_lo[m] <= LP_W'(PERIOD) * LP_W'(in_data.mag[m][LO_W-1:0]);
      end
    end
  end

  // floor(P*mag / 2^44) = floor((P*hi + floor(P*lo / 2^22)) / 2^22); reverse uses one more bit
  always_comb begin
    t      = '0;
    q      = '0;
    e_next = '0;
    for (int m = 0; m < 3; m++) begin
      t = (HP_W+1)'(d_hi[m]) + (HP_W+1)'(d_lo[m] >> LO_W);
      q = d_fwd[m] ? (t >> (ONE_SH - LO_W)) : (t >> (ONE_SH - LO_W + 1));
      case (d_op)
        OP_BRAKE: begin
          e_next.fwd[m] = 1'b1;
          e_next.cmp[m] = '0;
        end
        OP_COAST: begin
          e_next.fwd[m] = 1'b0;
          e_next.cmp[m] = COAST_CMP;
        end
        default: begin
          e_next.fwd[m] = d_fwd[m];
          e_next.cmp[m] = (q > (HP_W+1)'(CMP_MAX)) ? CMP_MAX : q[CMP_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= d_valid;
    end
    if (e_ready) begin
      e_data <= e_next;
    end
  end

  assign out_valid = e_valid;
  assign out_data  = e_data;

endmodule

`default_nettype wire

[hw/rtl/omni3_wheel_drive_mixer_unit.sv]
// Top level of the three-wheel omni drive mixer: config registers and the pipeline.
// Instantiates omni3_mix, omni3_sat and omni3_pwm; depends on omni3_pkg.
//
//  group  | dir | payload
//  s_*    | in  | drive command (tuser opcode, tdata velocities and spin rate)
//  m_*    | out | per-motor direction pin and PWM compare
//  cfg_*  | in  | register write: index, 16-bit data
//
// Input transactions pass five register stages (mix, scale, saturate, multiply, compare);
// one command per cycle is sustained while m_tready is held high.
// Each stage holds its item while the next is full, so a stall on m_tready fills
// the pipeline before s_tready drops. Reset clears valids and loads register defaults.
`default_nettype none

module omni3_wheel_drive_mixer_unit #(
  parameter int unsigned PWM_PERIOD = omni3_pkg::PWM_PERIOD_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,   // velocity_x, velocity_y, spin_rate
  input  wire logic [1:0]   s_tuser,   // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // forward_0, compare_0, forward_1, compare_1,
                                       // forward_2, compare_2, zero fill
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import omni3_pkg::*;

  logic [1:0]   heading_index;
  logic [15:0]  speed_gain;
  logic [15:0]  norm_gain;

  logic         mix_valid;
  logic         mix_ready;
  speed_set_t   mix_data;
  logic         sat_valid;
  logic         sat_ready;
  drive_set_t   sat_data;
  motor_set_t   pwm_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_index <= '0;
      speed_gain    <= SPEED_GAIN_RESET;
      norm_gain     <= NORM_GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADING:    heading_index <= cfg_data[1:0];
        REG_SPEED_GAIN: speed_gain    <= cfg_data;
        REG_NORM_GAIN:  norm_gain     <= cfg_data;
        default:        ;
      endcase
    end
  end

  omni3_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (opcode_t'(s_tuser)),
    .head       (heading_index),
    .velocity_x (s_tdata[15:0]),
    .velocity_y (s_tdata[31:16]),
    .spin_rate  (s_tdata[47:32]),
    .speed_gain (speed_gain),
    .norm_gain  (norm_gain),
    .out_valid  (mix_valid),
    .out_ready  (mix_ready),
    .out_data   (mix_data)
  );

  omni3_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (sat_valid),
    .out_ready (sat_ready),
    .out_data  (sat_data)
  );

  omni3_pwm #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_pwm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sat_valid),
    .in_ready  (sat_ready),
    .in_data   (sat_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (pwm_data)
  );

  assign m_tdata = {7'b0,
                    pwm_data.cmp[2], pwm_data.fwd[2],
                    pwm_data.cmp[1], pwm_data.fwd[1],
                    pwm_data.cmp[0], pwm_data.fwd[0]};

endmodule

`default_nettype wire

[test/omni3_mix_checker.sv]
// Scoreboard for omni3_wheel_drive_mixer_unit: watches the command, result and register
// channels, predicts the motor drive set of each command and compares it per field.
// Depends on omni3_pkg.
module omni3_mix_checker #(
  parameter int unsigned PWM_PERIOD = 899
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import omni3_pkg::*;

  localparam int REPORT_CAP = 40;

  logic [1:0]  heading;
  logic [15:0] speed_gain;
  logic [15:0] norm_gain;
  motor_set_t  drive_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(string what);
    if (fail_count < REPORT_CAP) $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  // speed in Q44 -> {pin, compare}
  function automatic logic [10:0] motor_level(longint s);
    longint      one;
    logic [63:0] per;
    logic [63:0] duty;
    logic        pin;
    one = 64'sd1 <<< ONE_SH;
    per = 64'(PWM_PERIOD & 32'hFFFF);
    if (s > one) s = one;
    if (s < -one) s = -one;
    if (s >= 0) begin
      pin = 1'b1;
      duty = (per * 64'(s)) >> ONE_SH;
    end else begin
      pin = 1'b0;
      duty = (per * 64'(one + s)) >> (ONE_SH + 1);
    end
    if (duty > 64'd1023) duty = 64'd1023;
    return {pin, duty[9:0]};
  endfunction

  function automatic motor_set_t predict_drive(opcode_t op, logic [47:0] d);
    motor_set_t  res;
    longint      vx, vy, sp, g;
    longint      w[3];
    logic [10:0] lv;
    int          k, m;
    res = '0;
    vx = $signed(d[15:0]);
    vy = $signed(d[31:16]);
    sp = $signed(d[47:32]);
    case (op)
      OP_MOVE: begin
        g = (longint'(norm_gain) * longint'(speed_gain)) >>> 14;
        w[0] = -vx * 65536;
        w[1] = vx * 32768 + vy * longint'(SIN60_Q16);
        w[2] = vx * 32768 - vy * longint'(SIN60_Q16);
        for (k = 0; k < 3; k++) begin
          m = (int'(heading) + k) % 3;
          lv = motor_level(w[k] * g);
          res.fwd[m] = lv[10];
          res.cmp[m] = lv[9:0];
        end
      end
      OP_SPIN: begin
        lv = motor_level(sp <<< 30);
        for (k = 0; k < 3; k++) begin
          res.fwd[k] = lv[10];
          res.cmp[k] = lv[9:0];
        end
      end
      OP_BRAKE: begin
        res.fwd = 3'b111;
      end
      default: begin
        for (k = 0; k < 3; k++)
          res.cmp[k] = (PWM_PERIOD > 1023) ? 10'd1023 : 10'(PWM_PERIOD);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    motor_set_t want;
    int         k;
    if (rst) begin
      heading = '0;
      speed_gain = SPEED_GAIN_RESET;
      norm_gain = NORM_GAIN_RESET;
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADING:    heading = cfg_data[1:0];
          REG_SPEED_GAIN: speed_gain = cfg_data;
          REG_NORM_GAIN:  norm_gain = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        drive_q.push_back(predict_drive(opcode_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          report($sformatf("result %h with nothing outstanding", m_tdata));
        end else begin
          want = drive_q.pop_front();
          for (k = 0; k < 3; k++) begin
            if (m_tdata[11*k] !== want.fwd[k])
              report($sformatf("motor %0d direction got %b want %b",
                               k, m_tdata[11*k], want.fwd[k]));
            if (m_tdata[11*k+1 +: 10] !== want.cmp[k])
              report($sformatf("motor %0d compare got %0d want %0d",
                               k, m_tdata[11*k+1 +: 10], want.cmp[k]));
          end
          if (m_tdata[39:33] !== 7'd0)
            report($sformatf("fill bits not zero: %b", m_tdata[39:33]));
        end
      end
    end
    pending <= drive_q.size();
  end

endmodule

[test/tb_omni3_wheel_drive_mixer_unit.sv]
// Testbench top for omni3_wheel_drive_mixer_unit: clock, reset, command and register
// stimulus with random back-pressure; checking is done by omni3_mix_checker.
// Depends on omni3_pkg and omni3_mix_checker.
module tb_omni3_wheel_drive_mixer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import omni3_pkg::*;

  localparam int unsigned PWM = PWM_PERIOD_DEFAULT;
  localparam int LATENCY = 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 55;
  localparam logic [1:0] REG_UNUSED = 2'd3;  // no register behind this index

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  omni3_wheel_drive_mixer_unit #(.PWM_PERIOD(PWM)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  omni3_mix_checker #(.PWM_PERIOD(PWM)) mix_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(0, 32768) - 16384);
    if (r < 8) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd16384;
      2: return 16'd32768;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // back-pressure on the result side
  initial begin : sink
    int n;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[omni3_wheel_drive_mixer_unit] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_cmd(opcode_t op, logic [15:0] vx, logic [15:0] vy, logic [15:0] sp);
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sp, vy, vx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random();
    opcode_t op;
    int      r;
    r = $urandom_range(0, 9);
    op = (r < 5) ? OP_MOVE : (r < 8) ? OP_SPIN : (r == 8) ? OP_BRAKE : OP_COAST;
    send_cmd(op, pick_vel(), pick_vel(), pick_vel());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stim
    logic [1:0]  hd;
    logic [15:0] sg, ng;
    int          p, i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed commands under the reset register values
    send_cmd(OP_BRAKE, 16'h1234, 16'hFEDC, 16'h8000);
    send_cmd(OP_COAST, 16'h7FFF, 16'h8000, 16'h4000);
    send_cmd(OP_SPIN, 16'h1111, 16'h2222, 16'h0000);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'h4000);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'hC000);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'h7FFF);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'h8000);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'hFFFF);
    send_cmd(OP_SPIN, 16'h0000, 16'h0000, 16'h0001);
    send_cmd(OP_MOVE, 16'h0000, 16'h0000, 16'h7FFF);
    send_cmd(OP_MOVE, 16'h4000, 16'h0000, 16'h0000);
    send_cmd(OP_MOVE, 16'hC000, 16'h0000, 16'h0000);
    send_cmd(OP_MOVE, 16'h0000, 16'h4000, 16'h0000);
    send_cmd(OP_MOVE, 16'h0000, 16'hC000, 16'h0000);
    send_cmd(OP_MOVE, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_cmd(OP_MOVE, 16'h8000, 16'h8000, 16'h0000);
    send_cmd(OP_MOVE, 16'h8000, 16'h7FFF, 16'h0000);
    send_cmd(OP_MOVE, 16'h2000, 16'hE000, 16'h0000);
    send_cmd(OP_MOVE, 16'hFFFF, 16'h0001, 16'h0000);
    send_cmd(OP_BRAKE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_COAST, 16'h0000, 16'h0000, 16'h0000);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (LATENCY + 3) @(posedge clk);
      case (p)
        0: begin hd = 2'd1; sg = 16'd16384; ng = 16'd16384; end
        1: begin hd = 2'd2; sg = 16'd32768; ng = 16'd32768; end
        2: begin hd = 2'd3; sg = 16'd0;     ng = 16'd16384; end
        3: begin hd = 2'd0; sg = 16'hFFFF;  ng = 16'hFFFF;  end
        4: begin hd = 2'd2; sg = SPEED_GAIN_RESET; ng = 16'd0; end
        default: begin
          hd = 2'($urandom_range(0, 3));
          sg = pick_gain();
          ng = pick_gain();
        end
      endcase
      write_reg(REG_HEADING, {14'($urandom_range(0, 16383)), hd});
      write_reg(REG_SPEED_GAIN, sg);
      write_reg(REG_NORM_GAIN, ng);
      if (p == 2) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      calm = (p == 5);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off until the pipeline has emptied
        if (p == 1 && i == PHASE_ITEMS / 2) wait_drained();
        send_random();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[omni3_wheel_drive_mixer_unit] OK");
    else
      $display("[omni3_wheel_drive_mixer_unit] ERROR");
    $finish;
  end

endmodule
